### rtl/gde_pkg.sv
// Shared types, codes and helpers for the gamepad direction event generator.
// Used by gde_classify and the top level; depends on nothing.
`timescale 1ns / 1ps

package gde_pkg;

    // Field widths fixed by the sample and event formats.
    localparam int STICK_W    = 16;
    localparam int DZ_W       = 15;
    localparam int DEV_W      = 2;
    localparam int BTN_W      = 4;
    localparam int DPAD_W     = 4;
    localparam int POS_W      = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DZ_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [DZ_W-1:0]  DEADZONE_RESET  = 15'd8000;
    localparam logic [DEV_W-1:0] DEVICE_ID_RESET = 2'd0;

    // Event kinds.
    localparam logic [KIND_W-1:0] KIND_MOVE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // D-pad bit positions.
    localparam int DPAD_UP    = 0;
    localparam int DPAD_DOWN  = 1;
    localparam int DPAD_LEFT  = 2;
    localparam int DPAD_RIGHT = 3;

    // Direction codes, two's complement: -1, 0 and +1.
    localparam logic [1:0] DIR_NEG  = 2'b11;
    localparam logic [1:0] DIR_ZERO = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;

    // Position step between neighboring directions.
    localparam logic [POS_W-1:0] POS_STEP = 16'd32767;

    typedef struct packed {
        logic [1:0] x;
        logic [1:0] y;
    } t_dir;

    // Maps a direction to its position, (dir + 1) * 32767.
    function automatic logic [POS_W-1:0] dir_to_pos(input logic [1:0] dir);
        logic [POS_W-1:0] pos;
        case (dir)
            DIR_NEG:  pos = '0;
            DIR_POS:  pos = {POS_STEP[POS_W-2:0], 1'b0};
            default:  pos = POS_STEP;
        endcase
        return pos;
    endfunction

endpackage

### rtl/gde_classify.sv
// Stick and d-pad classification into a per-axis direction.
// Depends on gde_pkg for field widths, direction codes and t_dir.
`timescale 1ns / 1ps

module gde_classify (
    input  logic signed [gde_pkg::STICK_W-1:0] i_stick_x,
    input  logic signed [gde_pkg::STICK_W-1:0] i_stick_y,
    input  logic        [gde_pkg::DPAD_W-1:0]  i_dpad,
    input  logic        [gde_pkg::DZ_W-1:0]    i_deadzone,
    output gde_pkg::t_dir                      o_dir
);

    logic signed [gde_pkg::STICK_W:0] pos_dz;
    logic signed [gde_pkg::STICK_W:0] neg_dz;
    logic signed [gde_pkg::STICK_W:0] sx;
    logic signed [gde_pkg::STICK_W:0] sy;
    logic [1:0] stick_dx;
    logic [1:0] stick_dy;

    // Widen everything to 17 bits so that the negated deadzone fits.
    assign pos_dz = $signed({2'b00, i_deadzone});
    assign neg_dz = -pos_dz;
    assign sx     = {i_stick_x[gde_pkg::STICK_W-1], i_stick_x};
    assign sy     = {i_stick_y[gde_pkg::STICK_W-1], i_stick_y};

    // Stick against the deadzone; Y is inverted so that up is negative.
    always_comb begin
        stick_dx = gde_pkg::DIR_ZERO;
        stick_dy = gde_pkg::DIR_ZERO;
        if (sx < neg_dz) begin
            stick_dx = gde_pkg::DIR_NEG;
        end else if (sx > pos_dz) begin
            stick_dx = gde_pkg::DIR_POS;
        end
        if (sy < neg_dz) begin
            stick_dy = gde_pkg::DIR_POS;
        end else if (sy > pos_dz) begin
            stick_dy = gde_pkg::DIR_NEG;
        end
    end

    // D-pad overrides per axis; right beats left and down beats up.
    always_comb begin
        o_dir.x = stick_dx;
        o_dir.y = stick_dy;
        if (i_dpad[gde_pkg::DPAD_RIGHT]) begin
            o_dir.x = gde_pkg::DIR_POS;
        end else if (i_dpad[gde_pkg::DPAD_LEFT]) begin
            o_dir.x = gde_pkg::DIR_NEG;
        end
        if (i_dpad[gde_pkg::DPAD_DOWN]) begin
            o_dir.y = gde_pkg::DIR_POS;
        end else if (i_dpad[gde_pkg::DPAD_UP]) begin
            o_dir.y = gde_pkg::DIR_NEG;
        end
    end

endmodule

### rtl/gamepad_direction_event_generator.sv
// Top level of the gamepad direction event generator: sample intake, event
// emitter and output register. Depends on gde_pkg and gde_classify.
`timescale 1ns / 1ps

// Usage:
// The input channel (i_valid / o_ready) takes one poll sample per request.
// A sample with i_read_ok low is taken and dropped without any effect.
// Each good sample is classified on the accepting edge, the stored
// direction and buttons are updated there, and the events it causes are
// parked in a work register. From there one event a cycle moves into the
// output register: a move event first if the direction changed, then one
// press or release event per changed face button, A first. o_last marks
// the final event of a sample.
// The first event of a sample passes through the work register and then
// the output register. Throughput: one event per cycle while the output
// register is free; a sample causes at most five events. Samples that
// cause no event leave the work register empty. A new sample is taken in
// the same cycle as the final event of the last one leaves that register.
// The output register holds its event while i_ready is low, and the work
// register and then the input channel stall behind it.
// Reset (synchronous, active low) centers the stored direction, releases
// all buttons, empties both registers and restores deadzone 8000, device 0.
// Configuration writes (i_cfg_we) take effect on the next edge.
module gamepad_direction_event_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [gde_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gde_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Sample channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_read_ok,
    input  logic signed [gde_pkg::STICK_W-1:0]  i_stick_x,
    input  logic signed [gde_pkg::STICK_W-1:0]  i_stick_y,
    input  logic [gde_pkg::BTN_W-1:0]           i_face_buttons,
    input  logic [gde_pkg::DPAD_W-1:0]          i_dpad,
    // Event channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [gde_pkg::KIND_W-1:0]          o_event_kind,
    output logic [gde_pkg::DEV_W-1:0]           o_device,
    output logic [gde_pkg::POS_W-1:0]           o_pos_x,
    output logic [gde_pkg::POS_W-1:0]           o_pos_y,
    output logic [gde_pkg::BTN_W-1:0]           o_buttons_now,
    output logic [gde_pkg::BTN_W-1:0]           o_changed_button,
    output logic                                o_last
);

    // Configuration registers
    logic [gde_pkg::DZ_W-1:0]   r_deadzone;
    logic [gde_pkg::DEV_W-1:0]  r_device_id;

    // Stored controller state
    gde_pkg::t_dir              r_prev_dir;
    logic [gde_pkg::BTN_W-1:0]  r_prev_btn;

    // Work register: events still to be emitted for one sample
    logic                       r_wk_valid;
    logic                       r_wk_move;
    logic [gde_pkg::BTN_W-1:0]  r_wk_mask;
    gde_pkg::t_dir              r_wk_dir;
    logic [gde_pkg::BTN_W-1:0]  r_wk_btn;

    // Output register
    logic                       r_out_valid;
    logic [gde_pkg::KIND_W-1:0] r_out_kind;
    logic [gde_pkg::POS_W-1:0]  r_out_pos_x;
    logic [gde_pkg::POS_W-1:0]  r_out_pos_y;
    logic [gde_pkg::BTN_W-1:0]  r_out_btn;
    logic [gde_pkg::BTN_W-1:0]  r_out_chg;
    logic                       r_out_last;

    gde_pkg::t_dir              cur_dir;
    logic                       in_acc;
    logic                       in_good;
    logic                       new_move;
    logic [gde_pkg::BTN_W-1:0]  new_mask;
    logic                       out_free;
    logic                       emit;
    logic [gde_pkg::BTN_W-1:0]  sel;
    logic [gde_pkg::BTN_W-1:0]  rem_mask;
    logic                       emit_last;
    logic [gde_pkg::KIND_W-1:0] n_kind;
    logic [gde_pkg::BTN_W-1:0]  n_chg;

    // Classification of the sample on the input ports.
    gde_classify u_classify (
        .i_stick_x  (i_stick_x),
        .i_stick_y  (i_stick_y),
        .i_dpad     (i_dpad),
        .i_deadzone (r_deadzone),
        .o_dir      (cur_dir)
    );

    // Handshake and change detection.
    assign out_free  = !r_out_valid || i_ready;
    assign emit      = r_wk_valid && out_free;
    assign o_ready   = !r_wk_valid || (emit && emit_last);
    assign in_acc    = i_valid && o_ready;
    assign in_good   = in_acc && i_read_ok;
    assign new_move  = (cur_dir != r_prev_dir);
    assign new_mask  = i_face_buttons ^ r_prev_btn;

    // Pick the next event: the move first, then the lowest changed button.
    always_comb begin
        sel = r_wk_mask & (~r_wk_mask + {{(gde_pkg::BTN_W-1){1'b0}}, 1'b1});
        if (r_wk_move) begin
            n_kind    = gde_pkg::KIND_MOVE;
            n_chg     = '0;
            rem_mask  = r_wk_mask;
        end else begin
            n_kind    = ((r_wk_btn & sel) != '0) ? gde_pkg::KIND_PRESS
                                                  : gde_pkg::KIND_RELEASE;
            n_chg     = sel;
            rem_mask  = r_wk_mask & ~sel;
        end
        emit_last = (rem_mask == '0);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone  <= gde_pkg::DEADZONE_RESET;
            r_device_id <= gde_pkg::DEVICE_ID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gde_pkg::CFG_DEADZONE:  r_deadzone  <= i_cfg_data;
                gde_pkg::CFG_DEVICE_ID: r_device_id <= i_cfg_data[gde_pkg::DEV_W-1:0];
                default: ;
            endcase
        end
    end

    // Stored direction and buttons follow every good sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_dir <= '0;
            r_prev_btn <= '0;
        end else if (in_good) begin
            r_prev_dir <= cur_dir;
            r_prev_btn <= i_face_buttons;
        end
    end

    // Work register: loaded by a sample with events, drained one per emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wk_valid <= 1'b0;
        end else if (in_acc) begin
            r_wk_valid <= in_good && (new_move || (new_mask != '0));
        end else if (emit && emit_last) begin
            r_wk_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_wk_move <= new_move;
            r_wk_mask <= new_mask;
            r_wk_dir  <= cur_dir;
            r_wk_btn  <= i_face_buttons;
        end else if (emit) begin
            r_wk_move <= 1'b0;
            r_wk_mask <= rem_mask;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_wk_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind  <= n_kind;
            r_out_pos_x <= gde_pkg::dir_to_pos(r_wk_dir.x);
            r_out_pos_y <= gde_pkg::dir_to_pos(r_wk_dir.y);
            r_out_btn   <= r_wk_btn;
            r_out_chg   <= n_chg;
            r_out_last  <= emit_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_event_kind     = r_out_kind;
    assign o_device         = r_device_id;
    assign o_pos_x          = r_out_pos_x;
    assign o_pos_y          = r_out_pos_y;
    assign o_buttons_now    = r_out_btn;
    assign o_changed_button = r_out_chg;
    assign o_last           = r_out_last;

`ifndef NO_ASSERTIONS
    // A loaded work register always has at least one event left.
    a_wk_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wk_valid |-> (r_wk_move || (r_wk_mask != '0)))
        else $error("work register holds no event");

    // Button events report exactly one button, move events none.
    a_chg_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_kind == gde_pkg::KIND_MOVE) ? (r_out_chg == '0)
                                                            : $onehot(r_out_chg)))
        else $error("changed-button mask does not match event kind");

    // A failed read leaves the stored buttons and direction alone.
    a_bad_read_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_read_ok) |=> ($stable(r_prev_btn) && $stable(r_prev_dir)))
        else $error("failed read changed the stored state");
`endif

endmodule

### dv/gamepad_direction_event_generator_tb.sv
// Self-checking testbench for the gamepad direction event generator.
// Needs gde_pkg and the rtl top level; checks each event against a predictor or typed row.
`timescale 1ns / 1ps

module gamepad_direction_event_generator_tb;

    // Local names for the package constants used here.
    localparam int STICK_W    = gde_pkg::STICK_W;
    localparam int DZ_W       = gde_pkg::DZ_W;
    localparam int DEV_W      = gde_pkg::DEV_W;
    localparam int BTN_W      = gde_pkg::BTN_W;
    localparam int DPAD_W     = gde_pkg::DPAD_W;
    localparam int POS_W      = gde_pkg::POS_W;
    localparam int KIND_W     = gde_pkg::KIND_W;
    localparam int CFG_IDX_W  = gde_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = gde_pkg::CFG_DATA_W;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE    = gde_pkg::CFG_DEADZONE;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID   = gde_pkg::CFG_DEVICE_ID;
    localparam logic [DZ_W-1:0]      DEADZONE_RESET  = gde_pkg::DEADZONE_RESET;
    localparam logic [DEV_W-1:0]     DEVICE_ID_RESET = gde_pkg::DEVICE_ID_RESET;
    localparam logic [KIND_W-1:0]    KIND_MOVE       = gde_pkg::KIND_MOVE;
    localparam logic [KIND_W-1:0]    KIND_PRESS      = gde_pkg::KIND_PRESS;
    localparam logic [KIND_W-1:0]    KIND_RELEASE    = gde_pkg::KIND_RELEASE;
    localparam int DPAD_UP    = gde_pkg::DPAD_UP;
    localparam int DPAD_DOWN  = gde_pkg::DPAD_DOWN;
    localparam int DPAD_LEFT  = gde_pkg::DPAD_LEFT;
    localparam int DPAD_RIGHT = gde_pkg::DPAD_RIGHT;
    localparam logic [1:0]       DIR_NEG  = gde_pkg::DIR_NEG;
    localparam logic [1:0]       DIR_ZERO = gde_pkg::DIR_ZERO;
    localparam logic [1:0]       DIR_POS  = gde_pkg::DIR_POS;
    localparam logic [POS_W-1:0] POS_STEP = gde_pkg::POS_STEP;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT        = 60;
    localparam int BURST_FROM     = 150;
    localparam int BURST_TO       = 230;
    localparam int ITEMS_PER_SET  = 90;

    // One poll sample as it crosses the input channel.
    typedef struct packed {
        logic              read_ok;
        logic [STICK_W-1:0] sx;
        logic [STICK_W-1:0] sy;
        logic [BTN_W-1:0]  btn;
        logic [DPAD_W-1:0] dp;
    } t_sample;

    // One event as it leaves the block.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DEV_W-1:0]  device;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [BTN_W-1:0]  buttons;
        logic [BTN_W-1:0]  changed;
        logic              last;
    } t_game_event;

    // A directed row; typed rows carry their event, the rest use the predictor.
    typedef struct {
        t_sample          s;
        bit               typed;
        int               n;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_read_ok;
    logic [STICK_W-1:0]    i_stick_x;
    logic [STICK_W-1:0]    i_stick_y;
    logic [BTN_W-1:0]      i_face_buttons;
    logic [DPAD_W-1:0]     i_dpad;
    logic                  o_valid;
    logic                  i_ready;
    logic [KIND_W-1:0]     o_event_kind;
    logic [DEV_W-1:0]      o_device;
    logic [POS_W-1:0]      o_pos_x;
    logic [POS_W-1:0]      o_pos_y;
    logic [BTN_W-1:0]      o_buttons_now;
    logic [BTN_W-1:0]      o_changed_button;
    logic                  o_last;

    // Tags that travel with a request from a typed directed row.
    bit               tag_typed;
    int               tag_n;
    logic [POS_W-1:0] tag_px;
    logic [POS_W-1:0] tag_py;

    // Predictor copy of configuration and stored state.
    logic [DZ_W-1:0]  cfg_deadzone = DEADZONE_RESET;
    logic [DEV_W-1:0] cfg_device   = DEVICE_ID_RESET;
    logic [1:0]       held_dir_x   = DIR_ZERO;
    logic [1:0]       held_dir_y   = DIR_ZERO;
    logic [BTN_W-1:0] held_buttons = '0;

    t_game_event pending_events[$];
    int          events_pending = 0;
    int          samples_taken  = 0;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;
    t_stim_row   dir_rows[$];
    logic [BTN_W-1:0] gen_btn   = '0;

    gamepad_direction_event_generator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_read_ok        (i_read_ok),
        .i_stick_x        (i_stick_x),
        .i_stick_y        (i_stick_y),
        .i_face_buttons   (i_face_buttons),
        .i_dpad           (i_dpad),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_event_kind     (o_event_kind),
        .o_device         (o_device),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_buttons_now    (o_buttons_now),
        .o_changed_button (o_changed_button),
        .o_last           (o_last)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Position of one axis: (direction + 1) * 32767.
    function automatic logic [POS_W-1:0] axis_position(input logic [1:0] dir);
        int d;
        d = $signed(dir);
        return POS_W'((d + 1) * int'(POS_STEP));
    endfunction

    // Classifies a sample, queues the events it causes when asked, and updates
    // the stored direction and buttons. Returns the number of events.
    function automatic int predict_events(input t_sample s, input bit emit);
        int          sx;
        int          sy;
        int          dz;
        int          n;
        logic [1:0]  dx;
        logic [1:0]  dy;
        logic [BTN_W-1:0] chg;
        t_game_event ev;
        t_game_event evs[5];
        n = 0;
        if (!s.read_ok)
            return 0;
        sx = $signed(s.sx);
        sy = $signed(s.sy);
        dz = int'(cfg_deadzone);
        dx = DIR_ZERO;
        dy = DIR_ZERO;
        if (sx < -dz)
            dx = DIR_NEG;
        else if (sx > dz)
            dx = DIR_POS;
        // Stick Y is inverted so that pushing up means a negative direction.
        if (sy < -dz)
            dy = DIR_POS;
        else if (sy > dz)
            dy = DIR_NEG;
        // The d-pad overrides the stick per axis; right and down win ties.
        if (s.dp[DPAD_LEFT])
            dx = DIR_NEG;
        if (s.dp[DPAD_RIGHT])
            dx = DIR_POS;
        if (s.dp[DPAD_UP])
            dy = DIR_NEG;
        if (s.dp[DPAD_DOWN])
            dy = DIR_POS;
        ev.device  = cfg_device;
        ev.pos_x   = axis_position(dx);
        ev.pos_y   = axis_position(dy);
        ev.buttons = s.btn;
        ev.last    = 1'b0;
        if (dx != held_dir_x || dy != held_dir_y) begin
            ev.kind    = KIND_MOVE;
            ev.changed = '0;
            evs[n]     = ev;
            n++;
        end
        // One press or release per changed face button, A first.
        chg = s.btn ^ held_buttons;
        for (int b = 0; b < BTN_W; b++) begin
            if (chg[b]) begin
                ev.kind    = s.btn[b] ? KIND_PRESS : KIND_RELEASE;
                ev.changed = BTN_W'(1) << b;
                evs[n]     = ev;
                n++;
            end
        end
        if (n > 0)
            evs[n-1].last = 1'b1;
        if (emit) begin
            for (int k = 0; k < n; k++)
                pending_events.push_back(evs[k]);
        end
        held_dir_x   = dx;
        held_dir_y   = dy;
        held_buttons = s.btn;
        return n;
    endfunction

    // Compares the event on the output ports with the oldest expected one.
    task automatic check_event(input t_game_event want);
        if (o_event_kind !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, o_event_kind);
            mismatch_count++;
        end
        if (o_device !== want.device) begin
            $error("device: expected %0d, got %0d", want.device, o_device);
            mismatch_count++;
        end
        if (o_pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, o_pos_x);
            mismatch_count++;
        end
        if (o_pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, o_pos_y);
            mismatch_count++;
        end
        if (o_buttons_now !== want.buttons) begin
            $error("buttons_now: expected %h, got %h", want.buttons, o_buttons_now);
            mismatch_count++;
        end
        if (o_changed_button !== want.changed) begin
            $error("changed_button: expected %h, got %h", want.changed, o_changed_button);
            mismatch_count++;
        end
        if (o_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, o_last);
            mismatch_count++;
        end
    endtask

    // Scoreboard: tracks register writes, predicts on each accepted request
    // and checks each accepted event.
    always @(posedge i_clk) begin
        t_sample     s;
        t_game_event typed_ev;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEADZONE:  cfg_deadzone = i_cfg_data[DZ_W-1:0];
                    CFG_DEVICE_ID: cfg_device   = i_cfg_data[DEV_W-1:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                if (pending_events.size() == 0) begin
                    $error("unexpected event: kind %0d pos %0d,%0d",
                           o_event_kind, o_pos_x, o_pos_y);
                    mismatch_count++;
                end else begin
                    check_event(pending_events.pop_front());
                end
            end
            if (i_valid && o_ready) begin
                s.read_ok = i_read_ok;
                s.sx      = i_stick_x;
                s.sy      = i_stick_y;
                s.btn     = i_face_buttons;
                s.dp      = i_dpad;
                void'(predict_events(s, !tag_typed));
                // Typed rows queue the event written in the table instead.
                if (tag_typed && tag_n == 1) begin
                    typed_ev.kind    = KIND_MOVE;
                    typed_ev.device  = cfg_device;
                    typed_ev.pos_x   = tag_px;
                    typed_ev.pos_y   = tag_py;
                    typed_ev.buttons = i_face_buttons;
                    typed_ev.changed = '0;
                    typed_ev.last    = 1'b1;
                    pending_events.push_back(typed_ev);
                end
                samples_taken <= samples_taken + 1;
            end
            events_pending <= pending_events.size();
        end
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Event receiver: random stalls, one long hold-off and a burst with no stalls.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && samples_taken >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (samples_taken >= BURST_FROM && samples_taken < BURST_TO) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 15);
        end
    end

    task automatic add_row(input bit ok, input int sx, input int sy, input int btn,
                           input int dp, input bit typed, input int n,
                           input int px, input int py);
        t_stim_row r;
        r.s.read_ok = ok;
        r.s.sx      = STICK_W'(sx);
        r.s.sy      = STICK_W'(sy);
        r.s.btn     = BTN_W'(btn);
        r.s.dp      = DPAD_W'(dp);
        r.typed     = typed;
        r.n         = n;
        r.px        = POS_W'(px);
        r.py        = POS_W'(py);
        dir_rows.push_back(r);
    endtask

    // Offers one request and holds it until accepted, then maybe idles.
    task automatic send_sample(input t_sample s, input bit typed, input int n,
                               input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
        i_valid        <= 1'b1;
        i_read_ok      <= s.read_ok;
        i_stick_x      <= s.sx;
        i_stick_y      <= s.sy;
        i_face_buttons <= s.btn;
        i_dpad         <= s.dp;
        tag_typed      <= typed;
        tag_n          <= n;
        tag_px         <= px;
        tag_py         <= py;
        do
            @(posedge i_clk);
        while (!o_ready);
        if (!(samples_taken >= BURST_FROM && samples_taken < BURST_TO)
                && $urandom_range(0, 99) < 12) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every expected event has come out.
    task automatic drain_events();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (events_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write, followed by the write enable going low again.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stick values biased toward the extremes and the deadzone edges.
    function automatic logic [STICK_W-1:0] pick_stick(input int dz);
        case ($urandom_range(0, 9))
            0: return STICK_W'(-32768);
            1: return STICK_W'(32767);
            2: return STICK_W'(dz);
            3: return STICK_W'(-dz);
            4: return STICK_W'(dz + 1);
            5: return STICK_W'(-dz - 1);
            6: return '0;
            default: return STICK_W'($urandom);
        endcase
    endfunction

    // Random polls: mostly good reads, buttons often held or with one bit flipped.
    task automatic run_random(input int count, input int dz);
        t_sample s;
        for (int i = 0; i < count; i++) begin
            s.read_ok = ($urandom_range(0, 99) >= 12);
            s.sx      = pick_stick(dz);
            s.sy      = pick_stick(dz);
            case ($urandom_range(0, 2))
                0: s.btn = gen_btn;
                1: s.btn = gen_btn ^ (BTN_W'(1) << $urandom_range(0, BTN_W - 1));
                default: s.btn = BTN_W'($urandom);
            endcase
            s.dp    = ($urandom_range(0, 99) < 55) ? '0 : DPAD_W'($urandom);
            gen_btn = s.btn;
            send_sample(s, 1'b0, 0, '0, '0);
        end
    endtask

    // Reset and stimulus.
    initial begin
        int dz_rand;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_read_ok      = 1'b0;
        i_stick_x      = '0;
        i_stick_y      = '0;
        i_face_buttons = '0;
        i_dpad         = '0;
        i_ready        = 1'b0;
        tag_typed      = 1'b0;
        tag_n          = 0;
        tag_px         = '0;
        tag_py         = '0;

        // Directed rows at reset values: deadzone 8000, device 0.
        add_row(0, -32768, 32767, 'hF, 'hF, 1, 0, 0, 0);       // failed read
        add_row(1, 0, 0, 0, 0, 1, 0, 0, 0);                    // nothing changed
        add_row(1, 32767, 0, 0, 0, 1, 1, 65534, 32767);
        add_row(1, -32768, 0, 0, 0, 1, 1, 0, 32767);
        add_row(1, 0, 32767, 0, 0, 1, 1, 32767, 0);
        add_row(1, 0, -32768, 0, 0, 1, 1, 32767, 65534);
        add_row(1, 8000, -8000, 0, 0, 1, 1, 32767, 32767);     // on the deadzone edge
        add_row(1, 8001, -8001, 0, 0, 1, 1, 65534, 65534);     // just past it
        add_row(1, -8000, 8000, 'h1, 0, 0, 0, 0, 0);           // move plus press
        add_row(1, 0, 0, 'h1, 0, 1, 0, 0, 0);
        add_row(1, 0, 0, 'hF, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 'hF, 0, 0, 0, 0);                  // move plus four releases
        add_row(1, 0, 0, 'hF, 'hF, 0, 0, 0, 0);                // both opposing d-pad pairs
        add_row(1, 32767, 0, 'hF, 'b0100, 0, 0, 0, 0);         // left overrides stick
        add_row(1, 32767, 0, 'hF, 'b0001, 0, 0, 0, 0);         // up only, X from stick
        add_row(1, 0, 32767, 'hF, 'b0010, 0, 0, 0, 0);         // down against stick up
        add_row(1, -32768, 0, 'hF, 'b1000, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 1, 0, 0, 0);                    // failed read keeps state
        add_row(1, -32768, 0, 'hF, 'b1000, 0, 0, 0, 0);
        add_row(1, -32767, 32767, 'b1010, 'b0011, 0, 0, 0, 0);
        add_row(1, -32768, -32768, 'b0101, 'b1100, 0, 0, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_sample(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].n,
                        dir_rows[i].px, dir_rows[i].py);
        gen_btn = 4'b0101;

        // Smallest deadzone, highest device number.
        drain_events();
        write_reg(CFG_DEADZONE, 15'd0);
        write_reg(CFG_DEVICE_ID, CFG_DATA_W'(3));
        run_random(ITEMS_PER_SET, 0);

        // Largest deadzone; unused data bits set on the device write.
        drain_events();
        write_reg(CFG_DEADZONE, 15'h7FFF);
        write_reg(CFG_DEVICE_ID, 15'h7FFD);
        run_random(ITEMS_PER_SET, 32767);

        drain_events();
        write_reg(CFG_DEADZONE, 15'd100);
        write_reg(CFG_DEVICE_ID, CFG_DATA_W'(2));
        run_random(ITEMS_PER_SET, 100);

        drain_events();
        dz_rand = $urandom_range(0, 32767);
        write_reg(CFG_DEADZONE, CFG_DATA_W'(dz_rand));
        write_reg(CFG_DEVICE_ID, CFG_DATA_W'($urandom));
        run_random(ITEMS_PER_SET, dz_rand);

        drain_events();
        if (mismatch_count == 0 && events_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
